>>> rtl/keypad_event_engine_core_defines.svh
// assertion macros of the keypad event engine rtl, used by the back end
`ifndef KEYPAD_EVENT_ENGINE_CORE_DEFINES_SVH
`define KEYPAD_EVENT_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad engine check failed");

// next-cycle implication, checked outside reset
`define KPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad engine check failed");

`endif

>>> rtl/kpe_pkg.sv
// types, constants and key tables of the keypad event engine
`default_nettype none

package kpe_pkg;

    localparam int COLUMNS     = 4;
    localparam int ROWS        = 5;
    localparam int TAP_ROW_LEN = 31;
    localparam int SCAN_W      = 20;
    localparam int MAP_SIZE    = 20;
    localparam int QUEUE_DEPTH = 2;

    // engine phases
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_PRESS    = 3'd2,
        PH_WAITLONG = 3'd3,
        PH_REPEAT   = 3'd4,
        PH_WAITREL  = 3'd5
    } phase_t;

    // event flags
    localparam logic [4:0] FL_DOWN    = 5'b00001;
    localparam logic [4:0] FL_UP      = 5'b00010;
    localparam logic [4:0] FL_PRESS   = 5'b00100;
    localparam logic [4:0] FL_LONG    = 5'b01000;
    localparam logic [4:0] FL_PREVIEW = 5'b10000;

    // key codes
    localparam logic [7:0] K_GREEN = 8'h0D;
    localparam logic [7:0] K_RED   = 8'h1B;
    localparam logic [7:0] K_UP    = 8'h13;
    localparam logic [7:0] K_DOWN  = 8'h14;
    localparam logic [7:0] K_LEFT  = 8'h15;
    localparam logic [7:0] K_RIGHT = 8'h16;
    localparam logic [7:0] K_STAR  = 8'h2A;
    localparam logic [7:0] K_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [3:0] TAP_STAR_ROW = 4'd11;
    localparam logic [5:0] TAP_FRESH    = 6'd63;

    // configuration register indexes
    localparam logic [1:0] REG_DEBOUNCE_POLLS   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS_MS    = 2'd1;
    localparam logic [1:0] REG_REPEAT_MS        = 2'd2;
    localparam logic [1:0] REG_ALPHA_TIMEOUT_MS = 2'd3;

    localparam logic [7:0]  RST_DEBOUNCE_POLLS   = 8'd4;
    localparam logic [15:0] RST_LONG_PRESS_MS    = 16'd5000;
    localparam logic [15:0] RST_REPEAT_MS        = 16'd5000;
    localparam logic [15:0] RST_ALPHA_TIMEOUT_MS = 16'd10000;

    // matrix position to key code, position c*ROWS+r
    localparam logic [7:0] KEY_ROM [MAP_SIZE] = '{
        8'h31, 8'h32, 8'h33, K_GREEN, K_RIGHT,
        8'h34, 8'h35, 8'h36, K_UP,    K_LEFT,
        8'h37, 8'h38, 8'h39, K_DOWN,  8'h00,
        K_STAR, 8'h30, K_HASH, K_RED, 8'h00
    };

    // decoded poll travelling from front to back
    typedef struct packed {
        logic              kind;
        logic [SCAN_W-1:0] scancode;
        logic              alpha_enable;
        logic [7:0]        elapsed_ms;
        logic              key_valid;
        logic [7:0]        code;
    } kpe_item_t;

    // configuration write
    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [15:0] data;
    } kpe_cfg_wr_t;

    // multi-tap character rom, rows 1 to 11, 0 outside a row
    function automatic logic [7:0] tap_char(input logic [3:0] row, input logic [5:0] idx);
        logic [255:0] bits;
        int unsigned  len;
        logic [7:0]   ch;
        bits = '0;
        len  = 0;
        ch   = '0;
        case (row)
            4'd1:    begin bits = 256'("0 ");        len = 2;  end
            4'd2:    begin
                bits = 256'({"1.!,@-:?()~/[]#<>=*+$%'", 8'h60, "&|_^{}"});
                len  = 30;
            end
            4'd3:    begin bits = 256'("abc2ABC");   len = 7;  end
            4'd4:    begin bits = 256'("def3DEF");   len = 7;  end
            4'd5:    begin bits = 256'("ghi4GHI");   len = 7;  end
            4'd6:    begin bits = 256'("jkl5JKL");   len = 7;  end
            4'd7:    begin bits = 256'("mno6MNO");   len = 7;  end
            4'd8:    begin bits = 256'("pqrs7PQRS"); len = 9;  end
            4'd9:    begin bits = 256'("tuv8TUV");   len = 7;  end
            4'd10:   begin bits = 256'("wxyz9WXYZ"); len = 9;  end
            4'd11:   begin bits = 256'("*");         len = 1;  end
            default: begin bits = '0;                len = 0;  end
        endcase
        if (idx < len && idx < TAP_ROW_LEN) begin
            ch = bits[(len - 1 - idx) * 8 +: 8];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/kpe_front.sv
// front end: matrix decode and classification of one poll
`default_nettype none

module kpe_front (
    input  wire logic                      kind,
    input  wire logic [kpe_pkg::SCAN_W-1:0] scancode,
    input  wire logic                      alpha_enable,
    input  wire logic [7:0]                elapsed_ms,
    output kpe_pkg::kpe_item_t             item
);
    import kpe_pkg::*;

    logic       single;
    logic [7:0] code;

    // one pressed key or none is valid
    assign single = (scancode != '0) && ((scancode & (scancode - 1'b1)) == '0);

    // last set position in scan order wins, as the code of a multi-key scan
    always_comb
    begin
        code = '0;
        for (int c = 0; c < COLUMNS; c++)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                if (c * ROWS + r < SCAN_W && c * ROWS + r < MAP_SIZE)
                begin
                    if (scancode[c * ROWS + r])
                    begin
                        code = KEY_ROM[c * ROWS + r];
                    end
                end
            end
        end
    end

    always_comb
    begin
        item.kind         = kind;
        item.scancode     = scancode;
        item.alpha_enable = alpha_enable;
        item.elapsed_ms   = elapsed_ms;
        item.key_valid    = single || (scancode == '0);
        item.code         = code;
    end

endmodule

`default_nettype wire

>>> rtl/kpe_fifo.sv
// short queue of decoded polls between front and back
`default_nettype none

module kpe_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  kpe_pkg::kpe_item_t push_item,
    input  wire logic          pop,
    output kpe_pkg::kpe_item_t head_item,
    output logic               head_valid,
    output logic               full
);
    import kpe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    kpe_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item  = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

>>> rtl/kpe_back.sv
// back end: keypad phase machine, timers, multi-tap and result register
`default_nettype none

`include "keypad_event_engine_core_defines.svh"

module kpe_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  kpe_pkg::kpe_cfg_wr_t cfg_wr,
    input  kpe_pkg::kpe_item_t  item,
    input  wire logic           item_valid,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          key_code,
    output logic [4:0]          key_flags,
    output logic                changed
);
    import kpe_pkg::*;

    // configuration
    logic [7:0]  debounce_polls_reg;
    logic [15:0] long_press_ms_reg;
    logic [15:0] repeat_ms_reg;
    logic [15:0] alpha_timeout_ms_reg;

    // engine state
    phase_t             phase_reg, phase_next;
    logic [7:0]         debounce_count_reg, debounce_count_next;
    logic [SCAN_W-1:0]  first_scancode_reg, first_scancode_next;
    logic [7:0]         held_key_reg, held_key_next;
    logic [3:0]         tap_key_reg, tap_key_next;
    logic [5:0]         tap_index_reg, tap_index_next;
    logic [15:0]        hold_timer_reg, hold_timer_next;
    logic [15:0]        tap_timer_reg, tap_timer_next;

    // result register
    logic               out_valid_reg;
    logic [7:0]         key_code_reg, key_code_next;
    logic [4:0]         key_flags_reg, key_flags_next;
    logic               changed_reg, changed_next;

    // working values
    logic [15:0] el_ext;
    logic [15:0] hold_dec;
    logic [15:0] tap_dec;
    phase_t      ph;
    logic [3:0]  nk;
    logic [3:0]  tk;
    logic [5:0]  ti;
    logic [7:0]  tap_ch;
    logic [7:0]  idle_ch;
    logic        is_arrow;

    assign pop = item_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_polls_reg   <= RST_DEBOUNCE_POLLS;
            long_press_ms_reg    <= RST_LONG_PRESS_MS;
            repeat_ms_reg        <= RST_REPEAT_MS;
            alpha_timeout_ms_reg <= RST_ALPHA_TIMEOUT_MS;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                REG_DEBOUNCE_POLLS:   debounce_polls_reg   <= cfg_wr.data[7:0];
                REG_LONG_PRESS_MS:    long_press_ms_reg    <= cfg_wr.data;
                REG_REPEAT_MS:        repeat_ms_reg        <= cfg_wr.data;
                REG_ALPHA_TIMEOUT_MS: alpha_timeout_ms_reg <= cfg_wr.data;
                default:              ;
            endcase
        end
    end

    // timers, forced phase and multi-tap step
    always_comb
    begin
        el_ext   = {8'd0, item.elapsed_ms};
        hold_dec = (hold_timer_reg > el_ext) ? hold_timer_reg - el_ext : '0;
        tap_dec  = (tap_timer_reg > el_ext) ? tap_timer_reg - el_ext : '0;

        ph = phase_reg;
        if (!item.key_valid && phase_reg != PH_IDLE && phase_reg != PH_DEBOUNCE)
        begin
            ph = PH_WAITREL;
        end

        nk = '0;
        if (item.code >= CH_ZERO && item.code <= CH_NINE)
        begin
            nk = 4'(item.code - CH_ZERO) + 4'd1;
        end
        else if (item.code == K_STAR)
        begin
            nk = TAP_STAR_ROW;
        end

        tk = tap_key_reg;
        ti = tap_index_reg;
        if (tk == '0)
        begin
            if (nk != '0)
            begin
                tk = nk;
                ti = '0;
            end
        end
        else if (nk == tk)
        begin
            ti = ti + 6'd1;
            if (tap_char(tk, ti) == '0)
            begin
                ti = '0;
            end
        end
        tap_ch  = tap_char(tk, ti);
        idle_ch = tap_char(tap_key_reg, tap_index_reg);

        is_arrow = (item.code == K_LEFT) || (item.code == K_RIGHT) ||
                   (item.code == K_UP) || (item.code == K_DOWN);
    end

    always_comb
    begin
        phase_next          = phase_reg;
        debounce_count_next = debounce_count_reg;
        first_scancode_next = first_scancode_reg;
        held_key_next       = held_key_reg;
        tap_key_next        = tap_key_reg;
        tap_index_next      = tap_index_reg;
        hold_timer_next     = hold_timer_reg;
        tap_timer_next      = tap_timer_reg;
        key_code_next       = '0;
        key_flags_next      = '0;
        changed_next        = 1'b0;

        if (pop)
        begin
            if (item.kind)
            begin
                held_key_next  = '0;
                tap_key_next   = '0;
                tap_index_next = '0;
                phase_next     = PH_WAITREL;
            end
            else
            begin
                hold_timer_next = hold_dec;
                tap_timer_next  = tap_dec;
                phase_next      = ph;
                case (ph)
                    PH_DEBOUNCE:
                    begin
                        if (debounce_count_reg >= debounce_polls_reg)
                        begin
                            if (first_scancode_reg == item.scancode)
                            begin
                                held_key_next = item.code;
                                phase_next    = PH_PRESS;
                            end
                            else
                            begin
                                phase_next = PH_WAITREL;
                            end
                        end
                        else
                        begin
                            debounce_count_next = debounce_count_reg + 8'd1;
                        end
                    end
                    PH_PRESS:
                    begin
                        key_code_next   = item.code;
                        key_flags_next  = FL_DOWN | FL_PRESS;
                        changed_next    = 1'b1;
                        hold_timer_next = long_press_ms_reg;
                        tap_timer_next  = alpha_timeout_ms_reg;
                        phase_next      = PH_WAITLONG;
                        if (item.alpha_enable)
                        begin
                            tap_key_next   = tk;
                            tap_index_next = ti;
                            if (tk != '0)
                            begin
                                key_code_next = tap_ch;
                                if (nk == tk)
                                begin
                                    key_flags_next = FL_PREVIEW;
                                end
                                else
                                begin
                                    // another key ends the pending tap
                                    key_flags_next = FL_PRESS;
                                    tap_key_next   = nk;
                                    tap_index_next = TAP_FRESH;
                                    phase_next     = PH_PRESS;
                                end
                            end
                        end
                    end
                    PH_WAITLONG:
                    begin
                        if (item.code == '0)
                        begin
                            key_code_next  = held_key_reg;
                            key_flags_next = FL_UP;
                            changed_next   = 1'b1;
                            phase_next     = PH_IDLE;
                        end
                        else if (hold_dec == '0)
                        begin
                            hold_timer_next = repeat_ms_reg;
                            key_code_next   = item.code;
                            key_flags_next  = FL_LONG | FL_DOWN;
                            changed_next    = 1'b1;
                            phase_next      = PH_REPEAT;
                        end
                    end
                    PH_REPEAT:
                    begin
                        changed_next = 1'b1;
                        if (item.code == '0)
                        begin
                            key_code_next  = held_key_reg;
                            key_flags_next = FL_LONG | FL_UP;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            key_code_next  = item.code;
                            key_flags_next = FL_LONG;
                            if (hold_dec == '0)
                            begin
                                hold_timer_next = repeat_ms_reg;
                                if (is_arrow)
                                begin
                                    key_flags_next = FL_LONG | FL_PRESS;
                                end
                            end
                        end
                    end
                    PH_WAITREL:
                    begin
                        if (item.scancode == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        if (item.scancode != '0)
                        begin
                            phase_next          = PH_DEBOUNCE;
                            debounce_count_next = '0;
                            first_scancode_next = item.scancode;
                            held_key_next       = '0;
                        end
                        // pending tap times out
                        if (tap_dec == '0 && tap_key_reg != '0)
                        begin
                            key_code_next  = idle_ch;
                            key_flags_next = FL_PRESS;
                            changed_next   = 1'b1;
                            tap_key_next   = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            debounce_count_reg <= '0;
            first_scancode_reg <= '0;
            held_key_reg       <= '0;
            tap_key_reg        <= '0;
            tap_index_reg      <= '0;
            hold_timer_reg     <= '0;
            tap_timer_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            debounce_count_reg <= debounce_count_next;
            first_scancode_reg <= first_scancode_next;
            held_key_reg       <= held_key_next;
            tap_key_reg        <= tap_key_next;
            tap_index_reg      <= tap_index_next;
            hold_timer_reg     <= hold_timer_next;
            tap_timer_reg      <= tap_timer_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            key_code_reg  <= key_code_next;
            key_flags_reg <= key_flags_next;
            changed_reg   <= changed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_code  = key_code_reg;
    assign key_flags = key_flags_reg;
    assign changed   = changed_reg;

    `KPE_ASSERT_IMP(a_quiet_result, clk, rst_n, out_valid_reg && !changed_reg, key_code_reg == '0 && key_flags_reg == '0)
    `KPE_ASSERT_NEXT(a_reset_request, clk, rst_n, pop && item.kind, phase_reg == PH_WAITREL && tap_key_reg == '0 && held_key_reg == '0)
    `KPE_ASSERT_NEXT(a_one_result, clk, rst_n, pop, out_valid_reg)

endmodule

`default_nettype wire

>>> rtl/keypad_event_engine_core.sv
// top level of the keypad event engine
`default_nettype none

// keypad event engine: each request on the input channel is one poll of the
// key matrix (or a reset request) and gives exactly one result on the output
// channel, in order. the block sustains one request per clock while the
// output is not stalled. a poll is decoded in the front end as it is accepted
// and lands in a two-entry queue; the back end takes one entry per cycle
// while the result register is free or being taken, runs the phase machine,
// timers and multi-tap step in that cycle and loads the result register, so a
// result passes through the queue and the result register before it is on
// the output. the result register holds while the output is stalled and the
// queue keeps absorbing requests until it holds two; input stall is raised
// only when the queue is full. configuration writes are always ready and take
// effect on the next cycle; write them only while no request is in flight.
module keypad_event_engine_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       kind,
    input  wire logic [kpe_pkg::SCAN_W-1:0] scancode,
    input  wire logic                       alpha_enable,
    input  wire logic [7:0]                 elapsed_ms,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [7:0]                      key_code,
    output logic [4:0]                      key_flags,
    output logic                            changed,
    // configuration write channel
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [15:0]                cfg_data
);
    import kpe_pkg::*;

    kpe_item_t   front_item;
    kpe_item_t   head_item;
    logic        head_valid;
    logic        queue_full;
    logic        push;
    logic        pop;
    kpe_cfg_wr_t cfg_wr;

    // registers can always be written
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_wr.valid = cfg_valid && cfg_ready;
        cfg_wr.index = cfg_index;
        cfg_wr.data  = cfg_data;
    end

    assign in_stall = queue_full;
    assign push     = in_valid && !in_stall;

    // decode and classify
    kpe_front u_front (
        .kind         (kind),
        .scancode     (scancode),
        .alpha_enable (alpha_enable),
        .elapsed_ms   (elapsed_ms),
        .item         (front_item)
    );

    // decouples input acceptance from result backpressure
    kpe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .pop        (pop),
        .head_item  (head_item),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    // phase machine and result register
    kpe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .item       (head_item),
        .item_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_code   (key_code),
        .key_flags  (key_flags),
        .changed    (changed)
    );

endmodule

`default_nettype wire

>>> bench/tb_keypad_event_engine_core.sv
// self-checking testbench of the keypad event engine core
module tb_keypad_event_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import kpe_pkg::*;

    // request kinds
    localparam logic KIND_POLL  = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    // no key at a matrix position
    localparam logic [7:0] NO_KEY = 8'h00;

    // scancodes used by the directed rows
    localparam logic [19:0] SC_NONE     = 20'h00000;
    localparam logic [19:0] SC_KEY2     = 20'd1 << 1;
    localparam logic [19:0] SC_KEY5     = 20'd1 << 6;
    localparam logic [19:0] SC_UP       = 20'd1 << 8;
    localparam logic [19:0] SC_TWO_KEYS = 20'h00003;
    localparam logic [19:0] SC_ALL      = 20'hFFFFF;

    // matrix position c*5+r to key code, written out independently of the rtl
    localparam logic [7:0] KEY_AT [20] = '{
        "1",    "2", "3",    K_GREEN, K_RIGHT,
        "4",    "5", "6",    K_UP,    K_LEFT,
        "7",    "8", "9",    K_DOWN,  NO_KEY,
        K_STAR, "0", K_HASH, K_RED,   NO_KEY
    };

    // positions of the digit and star keys, and of the arrows
    localparam int TAP_BITS [11] = '{0, 1, 2, 5, 6, 7, 10, 11, 12, 16, 15};
    localparam int ARROW_BITS [4] = '{4, 8, 9, 13};

    typedef struct packed {
        logic        kind;
        logic [19:0] scan;
        logic        alpha;
        logic [7:0]  elapsed;
    } poll_t;

    typedef struct packed {
        logic [7:0] code;
        logic [4:0] flags;
        logic       chg;
    } event_t;

    localparam event_t NO_EVENT = '0;

    // one row of the directed table: a register write or a poll request
    typedef struct {
        bit          wr;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        poll_t       p;
        bit          typed;
        event_t      want;
    } step_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        kind         = 1'b0;
    logic [19:0] scancode     = '0;
    logic        alpha_enable = 1'b0;
    logic [7:0]  elapsed_ms   = '0;
    logic        out_stall    = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [1:0]  cfg_index    = '0;
    logic [15:0] cfg_data     = '0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  key_code;
    logic [4:0]  key_flags;
    logic        changed;
    logic        cfg_ready;

    keypad_event_engine_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .scancode     (scancode),
        .alpha_enable (alpha_enable),
        .elapsed_ms   (elapsed_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_code     (key_code),
        .key_flags    (key_flags),
        .changed      (changed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // configuration as the engine should see it, starts at the reset values
    logic [7:0]  cfg_debounce = 8'd4;
    logic [15:0] cfg_long     = 16'd5000;
    logic [15:0] cfg_repeat   = 16'd5000;
    logic [15:0] cfg_alpha    = 16'd10000;

    // engine state mirror
    phase_t      eng_phase  = PH_IDLE;
    logic [7:0]  bounce_cnt = '0;
    logic [19:0] first_scan = '0;
    logic [7:0]  held_code  = '0;
    logic [3:0]  tap_row    = '0;
    logic [5:0]  tap_pos    = '0;
    logic [15:0] hold_left  = '0;
    logic [15:0] tap_left   = '0;

    event_t pending_events [$];
    step_t  steps [$];
    int     bad_events = 0;
    int     polls_left = 0;
    bit     steady     = 1'b0;

    // phone-style character rows, 1 to 11; 0 past the end of a row
    function automatic logic [7:0] multitap_char(input logic [3:0] row, input logic [5:0] pos);
        string s;
        s = "";
        case (row)
            4'd1:    s = "0 ";
            4'd2:    s = "1.!,@-:?()~/[]#<>=*+$%' &|_^{}";
            4'd3:    s = "abc2ABC";
            4'd4:    s = "def3DEF";
            4'd5:    s = "ghi4GHI";
            4'd6:    s = "jkl5JKL";
            4'd7:    s = "mno6MNO";
            4'd8:    s = "pqrs7PQRS";
            4'd9:    s = "tuv8TUV";
            4'd10:   s = "wxyz9WXYZ";
            4'd11:   s = "*";
            default: s = "";
        endcase
        if (pos >= s.len() || pos >= TAP_ROW_LEN)
            return 8'h00;
        // the symbol row holds a back quote at position 23
        if (row == 4'd2 && pos == 6'd23)
            return 8'h60;
        return s[pos];
    endfunction

    // advance the engine mirror by one request and return the event it reports
    function automatic event_t predict_event(input poll_t p);
        event_t     ev;
        logic [7:0] code;
        logic [3:0] nk;
        int         hits;
        int         b;
        ev   = NO_EVENT;
        code = NO_KEY;
        nk   = '0;
        hits = 0;
        if (p.kind == KIND_RESET) begin
            held_code = NO_KEY;
            tap_row   = '0;
            tap_pos   = '0;
            eng_phase = PH_WAITREL;
            return ev;
        end
        hold_left = (hold_left > 16'(p.elapsed)) ? hold_left - 16'(p.elapsed) : 16'd0;
        tap_left  = (tap_left > 16'(p.elapsed)) ? tap_left - 16'(p.elapsed) : 16'd0;

        // last set position wins, more than one key is invalid
        for (b = 0; b < 20; b++) begin
            if (p.scan[b]) begin
                hits++;
                code = KEY_AT[b];
            end
        end
        if (eng_phase > PH_DEBOUNCE && hits > 1)
            eng_phase = PH_WAITREL;

        case (eng_phase)
            PH_DEBOUNCE: begin
                if (bounce_cnt >= cfg_debounce) begin
                    if (first_scan == p.scan) begin
                        held_code = code;
                        eng_phase = PH_PRESS;
                    end else begin
                        eng_phase = PH_WAITREL;
                    end
                end else begin
                    bounce_cnt = bounce_cnt + 8'd1;
                end
            end
            PH_PRESS: begin
                ev.code   = code;
                ev.flags  = FL_DOWN | FL_PRESS;
                ev.chg    = 1'b1;
                hold_left = cfg_long;
                tap_left  = cfg_alpha;
                eng_phase = PH_WAITLONG;
                if (p.alpha) begin
                    if (code >= CH_ZERO && code <= CH_NINE)
                        nk = 4'(code - CH_ZERO + 8'd1);
                    else if (code == K_STAR)
                        nk = TAP_STAR_ROW;
                    if (tap_row == 4'd0) begin
                        if (nk != 4'd0) begin
                            tap_row = nk;
                            tap_pos = '0;
                        end
                    end else if (nk == tap_row) begin
                        tap_pos = tap_pos + 6'd1;
                        if (multitap_char(tap_row, tap_pos) == 8'h00)
                            tap_pos = '0;
                    end
                    if (tap_row != 4'd0) begin
                        ev.code = multitap_char(tap_row, tap_pos);
                        if (nk == tap_row) begin
                            ev.flags = FL_PREVIEW;
                        end else begin
                            // another key ends the pending tap and starts over
                            ev.flags  = FL_PRESS;
                            tap_row   = nk;
                            tap_pos   = TAP_FRESH;
                            eng_phase = PH_PRESS;
                        end
                    end
                end
            end
            PH_WAITLONG: begin
                if (code == NO_KEY) begin
                    ev.code   = held_code;
                    ev.flags  = FL_UP;
                    ev.chg    = 1'b1;
                    eng_phase = PH_IDLE;
                end else if (hold_left == 16'd0) begin
                    hold_left = cfg_repeat;
                    ev.code   = code;
                    ev.flags  = FL_LONG | FL_DOWN;
                    ev.chg    = 1'b1;
                    eng_phase = PH_REPEAT;
                end
            end
            PH_REPEAT: begin
                ev.chg = 1'b1;
                if (code == NO_KEY) begin
                    ev.code   = held_code;
                    ev.flags  = FL_LONG | FL_UP;
                    eng_phase = PH_IDLE;
                end else begin
                    ev.code  = code;
                    ev.flags = FL_LONG;
                    if (hold_left == 16'd0) begin
                        hold_left = cfg_repeat;
                        if (code == K_LEFT || code == K_RIGHT || code == K_UP || code == K_DOWN)
                            ev.flags = FL_LONG | FL_PRESS;
                    end
                end
            end
            PH_WAITREL: begin
                if (p.scan == SC_NONE)
                    eng_phase = PH_IDLE;
            end
            default: begin
                eng_phase = PH_IDLE;
                if (p.scan != SC_NONE) begin
                    eng_phase  = PH_DEBOUNCE;
                    bounce_cnt = '0;
                    first_scan = p.scan;
                    held_code  = NO_KEY;
                end
                // pending tap runs out while idle
                if (tap_left == 16'd0 && tap_row != 4'd0) begin
                    ev.code  = multitap_char(tap_row, tap_pos);
                    ev.flags = FL_PRESS;
                    ev.chg   = 1'b1;
                    tap_row  = '0;
                end
            end
        endcase
        return ev;
    endfunction

    function automatic void add_write(input logic [1:0] idx, input logic [15:0] val);
        step_t s;
        s = '{wr: 1'b1, reg_idx: idx, reg_val: val, p: '0, typed: 1'b0, want: NO_EVENT};
        steps.push_back(s);
    endfunction

    function automatic void add_poll(input poll_t p);
        step_t s;
        s = '{wr: 1'b0, reg_idx: '0, reg_val: '0, p: p, typed: 1'b0, want: NO_EVENT};
        steps.push_back(s);
    endfunction

    function automatic void add_checked(input poll_t p, input event_t want);
        step_t s;
        s = '{wr: 1'b0, reg_idx: '0, reg_val: '0, p: p, typed: 1'b1, want: want};
        steps.push_back(s);
    endfunction

    // one poll request: random gaps at the falling edge, then hold until taken
    task automatic send_poll(input poll_t p, input bit typed, input event_t want);
        event_t ev;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 19) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= p.kind;
        scancode     <= p.scan;
        alpha_enable <= p.alpha;
        elapsed_ms   <= p.elapsed;
        do
            @(posedge clk);
        while (in_stall);
        ev = predict_event(p);
        pending_events.push_back(typed ? want : ev);
    endtask

    // random part: requests come out of a per-phase budget, sequences may be cut short
    task automatic drive_poll(input logic k, input logic [19:0] sc, input logic a,
                              input logic [7:0] el);
        if (polls_left > 0) begin
            polls_left--;
            send_poll({k, sc, a, el}, 1'b0, NO_EVENT);
        end
    endtask

    task automatic hold_polls(input logic [19:0] sc, input logic a, input int n,
                              input int el_lo, input int el_hi);
        repeat (n)
            drive_poll(KIND_POLL, sc, a, 8'($urandom_range(el_lo, el_hi)));
    endtask

    // drop valid and wait until every result is back, then let the engine idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DEBOUNCE_POLLS: cfg_debounce = val[7:0];
            REG_LONG_PRESS_MS:  cfg_long     = val;
            REG_REPEAT_MS:      cfg_repeat   = val;
            default:            cfg_alpha    = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one randomly chosen key sequence
    task automatic play_sequence();
        int          sel;
        int          taps;
        int          k;
        logic [19:0] key;
        logic [19:0] other;
        logic        a;
        sel = $urandom_range(0, 99);
        key = 20'd1 << $urandom_range(0, 19);
        a   = 1'($urandom_range(0, 1));
        if (sel < 30) begin
            // clean press and release of any position
            hold_polls(key, a, int'(cfg_debounce) + 2 + $urandom_range(0, 12), 0, 255);
            hold_polls(SC_NONE, a, $urandom_range(1, 4), 0, 255);
        end else if (sel < 55) begin
            // multi-tap burst, short gaps keep the tap pending, sometimes past a row end
            key  = 20'd1 << TAP_BITS[$urandom_range(0, 10)];
            taps = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 34) : $urandom_range(1, 12);
            for (k = 0; k < taps; k++) begin
                if ($urandom_range(0, 3) == 0)
                    key = 20'd1 << TAP_BITS[$urandom_range(0, 10)];
                hold_polls(key, 1'b1, int'(cfg_debounce) + 2, 0, 20);
                hold_polls(SC_NONE, 1'b1, $urandom_range(1, 2), 0, 20);
            end
            // idle long enough, most of the time, to commit the character
            hold_polls(SC_NONE, 1'($urandom_range(0, 1)), $urandom_range(0, 20), 100, 255);
        end else if (sel < 70) begin
            // long hold, mostly arrows for the repeat press
            if ($urandom_range(0, 2) != 0)
                key = 20'd1 << ARROW_BITS[$urandom_range(0, 3)];
            hold_polls(key, a, int'(cfg_debounce) + 2 + $urandom_range(0, 40), 100, 255);
            hold_polls(SC_NONE, a, 1, 0, 255);
        end else if (sel < 85) begin
            // noise: any fields, multiple keys, reset requests
            for (k = $urandom_range(1, 6); k > 0; k--) begin
                if ($urandom_range(0, 2) == 0)
                    other = 20'($urandom);
                else
                    other = (20'd1 << $urandom_range(0, 19)) | (20'd1 << $urandom_range(0, 19));
                drive_poll(1'($urandom_range(0, 9) == 0), other, 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
            end
        end else begin
            // bounce or interrupted press
            hold_polls(key, a, $urandom_range(1, int'(cfg_debounce) + 1), 0, 255);
            case ($urandom_range(0, 2))
                0:       hold_polls(key | (20'd1 << $urandom_range(0, 19)), a,
                                    int'(cfg_debounce) + 2, 0, 255);
                1:       hold_polls(20'd1 << $urandom_range(0, 19), a, 2, 0, 255);
                default: drive_poll(KIND_RESET, key, a, 8'($urandom_range(0, 255)));
            endcase
            hold_polls(SC_NONE, a, $urandom_range(1, 3), 0, 255);
        end
    endtask

    task automatic run_phase(input logic [7:0] dbn, input logic [15:0] lp,
                             input logic [15:0] rp, input logic [15:0] at, input int n);
        settle();
        write_reg(REG_DEBOUNCE_POLLS, {8'h00, dbn});
        write_reg(REG_LONG_PRESS_MS, lp);
        write_reg(REG_REPEAT_MS, rp);
        write_reg(REG_ALPHA_TIMEOUT_MS, at);
        polls_left = n;
        while (polls_left > 0)
            play_sequence();
    endtask

    // receiver stalls at random, with probability 19 in 100, never during a steady stretch
    always @(negedge clk)
        out_stall <= rst_n && !steady && ($urandom_range(0, 99) < 19);

    // compare each result with the oldest expected event
    always @(posedge clk) begin : check_events
        event_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_events.size() == 0) begin
                bad_events++;
                if (bad_events <= 10)
                    $display("unexpected result: code %h flags %b changed %b",
                             key_code, key_flags, changed);
            end else begin
                want = pending_events.pop_front();
                if (key_code !== want.code || key_flags !== want.flags
                        || changed !== want.chg) begin
                    bad_events++;
                    if (bad_events <= 10)
                        $display("result mismatch: expected code %h flags %b changed %b, %s",
                                 want.code, want.flags, want.chg,
                                 $sformatf("got code %h flags %b changed %b",
                                           key_code, key_flags, changed));
                end
            end
        end
    end

    // hard limit on the whole run
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : main
        int k;

        // directed rows, checked ones are plain from the key map and the timers
        // reset request right after reset, then a quiet poll back to idle
        add_checked({KIND_RESET, SC_NONE, 1'b0, 8'd0}, NO_EVENT);
        add_checked({KIND_POLL, SC_NONE, 1'b0, 8'd255}, NO_EVENT);
        // no debounce and short timers so long press and repeat come quickly
        add_write(REG_DEBOUNCE_POLLS, 16'd0);
        add_write(REG_LONG_PRESS_MS, 16'd300);
        add_write(REG_REPEAT_MS, 16'd200);
        add_write(REG_ALPHA_TIMEOUT_MS, 16'd400);
        // digit held into long press and one repeat, then released
        add_poll({KIND_POLL, SC_KEY5, 1'b0, 8'd0});
        add_poll({KIND_POLL, SC_KEY5, 1'b0, 8'd0});
        add_checked({KIND_POLL, SC_KEY5, 1'b0, 8'd10}, {"5", FL_DOWN | FL_PRESS, 1'b1});
        add_poll({KIND_POLL, SC_KEY5, 1'b0, 8'd255});
        add_checked({KIND_POLL, SC_KEY5, 1'b0, 8'd255}, {"5", FL_LONG | FL_DOWN, 1'b1});
        add_poll({KIND_POLL, SC_KEY5, 1'b0, 8'd200});
        add_checked({KIND_POLL, SC_NONE, 1'b0, 8'd0}, {"5", FL_LONG | FL_UP, 1'b1});
        // arrow held until its repeat gives a press
        add_poll({KIND_POLL, SC_UP, 1'b0, 8'd0});
        add_poll({KIND_POLL, SC_UP, 1'b0, 8'd0});
        add_checked({KIND_POLL, SC_UP, 1'b0, 8'd0}, {K_UP, FL_DOWN | FL_PRESS, 1'b1});
        add_poll({KIND_POLL, SC_UP, 1'b0, 8'd255});
        add_poll({KIND_POLL, SC_UP, 1'b0, 8'd255});
        add_checked({KIND_POLL, SC_UP, 1'b0, 8'd200}, {K_UP, FL_LONG | FL_PRESS, 1'b1});
        // second key joins: invalid, wait for release
        add_checked({KIND_POLL, SC_TWO_KEYS, 1'b0, 8'd0}, NO_EVENT);
        add_checked({KIND_POLL, SC_NONE, 1'b0, 8'd0}, NO_EVENT);
        // one multi-tap on the 2 key, preview then commit on timeout
        add_poll({KIND_POLL, SC_KEY2, 1'b1, 8'd0});
        add_poll({KIND_POLL, SC_KEY2, 1'b1, 8'd0});
        add_checked({KIND_POLL, SC_KEY2, 1'b1, 8'd0}, {"a", FL_PREVIEW, 1'b1});
        add_checked({KIND_POLL, SC_NONE, 1'b1, 8'd0}, {"2", FL_UP, 1'b1});
        add_poll({KIND_POLL, SC_NONE, 1'b1, 8'd255});
        add_checked({KIND_POLL, SC_NONE, 1'b1, 8'd255}, {"a", FL_PRESS, 1'b1});
        // all fields at their top values
        add_checked({KIND_POLL, SC_ALL, 1'b1, 8'd255}, NO_EVENT);
        add_checked({KIND_RESET, SC_ALL, 1'b1, 8'd255}, NO_EVENT);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (steps[i]) begin
            if (steps[i].wr) begin
                settle();
                write_reg(steps[i].reg_idx, steps[i].reg_val);
            end else begin
                send_poll(steps[i].p, steps[i].typed, steps[i].want);
            end
        end

        // random sequences under several settings, extremes among them
        run_phase(8'd2, 16'd300, 16'd200, 16'd600, 220);
        steady = 1'b1;
        run_phase(8'd0, 16'd0, 16'd0, 16'd0, 120);
        steady = 1'b0;
        run_phase(8'd255, 16'd100, 16'd50, 16'd200, 270);
        run_phase(8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 100);
        run_phase(8'($urandom_range(0, 6)), 16'($urandom_range(0, 3000)),
                  16'($urandom_range(0, 1500)), 16'($urandom_range(0, 3000)), 150);

        // drain, with a bound
        @(negedge clk);
        in_valid <= 1'b0;
        for (k = 0; k < 5000 && pending_events.size() != 0; k++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_events.size() != 0) begin
            bad_events++;
            if (bad_events <= 10)
                $display("results missing: %0d", pending_events.size());
        end

        if (bad_events == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
